// ----- hw/rtl/rcpr_pkg.sv -----
`default_nettype none
package rcpr_pkg;

  // fixed field widths
  localparam int PIX_W      = 8;
  localparam int IDX_W      = 12;
  localparam int CFG_W      = 13;
  localparam int CFG_ADDR_W = 2;
  localparam int MODE_W     = 2;
  localparam int Q_W        = 8;
  localparam int DIV_IDX_W  = 3;

  // first (most significant) quotient bit resolved by the divider
  localparam logic [DIV_IDX_W-1:0] DIV_LAST = DIV_IDX_W'(Q_W - 1);

  // saturation ceiling of a reduced value
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // reduction modes, any other code means truncated mean
  localparam logic [MODE_W-1:0] MODE_MIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEAN = 2'd2;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_REDUCE_MODE   = 2'd0,
    CFG_LAYOUT_COLUMN = 2'd1,
    CFG_FRAME_WIDTH   = 2'd2,
    CFG_FRAME_HEIGHT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [MODE_W-1:0] reduce_mode;
    logic              layout_column;
    logic [CFG_W-1:0]  frame_width;
    logic [CFG_W-1:0]  frame_height;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic                 accept;
    logic                 comb;
    logic                 div_chk;
    logic                 div_step;
    logic [DIV_IDX_W-1:0] div_idx;
    logic                 out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;
    logic mean;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rcpr_ram.sv -----
`default_nettype none
module rcpr_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rcpr_ctrl.sv -----
`default_nettype none
module rcpr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  output      logic               out_valid,
  input  wire logic               out_stall,
  input  wire rcpr_pkg::dp_sts_t  sts,
  output      rcpr_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMB,
    S_DIV_CHK,
    S_DIV,
    S_FIN
  } state_t;

  state_t                             state_r, state_nxt;
  logic [rcpr_pkg::DIV_IDX_W-1:0]     idx_r, idx_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // pixel sequence: accept, combine; for a result, optional divide, result
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_COMB;
        end
      end
      S_COMB: begin
        cmd.comb = 1'b1;
        if (sts.emit) begin
          state_nxt = sts.mean ? S_DIV_CHK : S_FIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV_CHK: begin
        cmd.div_chk = 1'b1;
        idx_nxt     = rcpr_pkg::DIV_LAST;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_idx  = idx_r;
        if (idx_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register valid: set on load, cleared when the transaction is taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending transaction");

  // an accepted pixel is combined in the following cycle
  a_accept_then_comb: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_COMB))
    else $error("accepted pixel not combined next cycle");

  // the divider finishes all quotient bits before the result stage
  a_div_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && idx_r != '0) |=> (state_r == S_DIV))
    else $error("divider left before its last step");

endmodule
`default_nettype wire

// ----- hw/rtl/rcpr_dp.sv -----
`default_nettype none
module rcpr_dp #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rcpr_pkg::cfg_t              cfg,
  input  wire rcpr_pkg::ctrl_cmd_t         cmd,
  output      rcpr_pkg::dp_sts_t           sts,
  input  wire logic [rcpr_pkg::PIX_W-1:0]  in_pixel,
  output      logic [rcpr_pkg::PIX_W-1:0]  out_reduced_value,
  output      logic [rcpr_pkg::IDX_W-1:0]  out_line_index,
  output      logic                        out_last_of_frame
);

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int EFF_W   = $clog2(MAX_DIM + 1);
  localparam int ACC_W   = $clog2(MAX_DIM * 255 + 1);
  localparam int DIV_W   = (ACC_W > EFF_W + rcpr_pkg::Q_W) ? ACC_W : EFF_W + rcpr_pkg::Q_W;

  // effective frame size
  logic [EFF_W-1:0] w_eff, h_eff;
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;

  assign w_eff = (cfg.frame_width == '0) ? EFF_W'(1) :
                 (32'(cfg.frame_width) > 32'(MAX_WIDTH)) ? EFF_W'(MAX_WIDTH) :
                 EFF_W'(cfg.frame_width);
  assign h_eff = (cfg.frame_height == '0) ? EFF_W'(1) :
                 (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) ? EFF_W'(MAX_HEIGHT) :
                 EFF_W'(cfg.frame_height);
  assign w_m1  = COL_W'(w_eff - EFF_W'(1));
  assign h_m1  = ROW_W'(h_eff - EFF_W'(1));

  // raster position, clamped to the current size
  logic [COL_W-1:0] col_r, col_sat;
  logic [ROW_W-1:0] row_r, row_sat;
  logic             last_col, last_row;

  assign last_col = (col_r >= w_m1);
  assign last_row = (row_r >= h_m1);
  assign col_sat  = last_col ? w_m1 : col_r;
  assign row_sat  = last_row ? h_m1 : row_r;

  // per-pixel context captured on accept
  logic [rcpr_pkg::PIX_W-1:0] px_r;
  logic [COL_W-1:0]           addr_r;
  logic                       first_r;
  logic                       emit_r;
  logic [rcpr_pkg::IDX_W-1:0] line_r;
  logic                       lastf_r;
  logic [EFF_W-1:0]           cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r    <= in_pixel;
      addr_r  <= col_sat;
      first_r <= cfg.layout_column ? (row_sat == '0) : (col_sat == '0);
      emit_r  <= cfg.layout_column ? last_row : last_col;
      line_r  <= cfg.layout_column ? rcpr_pkg::IDX_W'(col_sat) : rcpr_pkg::IDX_W'(row_sat);
      lastf_r <= cfg.layout_column ? last_col : last_row;
      cnt_r   <= cfg.layout_column ? h_eff : w_eff;
    end
  end

  // column accumulator store
  logic [ACC_W-1:0] ram_rdata;
  logic [ACC_W-1:0] acc_new;
  logic             ram_we;

  assign ram_we = cmd.comb && cfg.layout_column;

  rcpr_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (addr_r),
    .wr_data (acc_new),
    .rd_en   (cmd.accept),
    .rd_addr (col_sat),
    .rd_data (ram_rdata)
  );

  // combine pixel with its row or column accumulator
  logic [ACC_W-1:0] row_acc_r;
  logic [ACC_W-1:0] acc_old, px_ext, acc_comb;

  assign acc_old = cfg.layout_column ? ram_rdata : row_acc_r;
  assign px_ext  = ACC_W'(px_r);

  always_comb begin
    case (cfg.reduce_mode)
      rcpr_pkg::MODE_MIN: acc_comb = (px_ext < acc_old) ? px_ext : acc_old;
      rcpr_pkg::MODE_MAX: acc_comb = (px_ext > acc_old) ? px_ext : acc_old;
      default:            acc_comb = acc_old + px_ext;
    endcase
  end

  assign acc_new = first_r ? px_ext : acc_comb;

  // position counters and row accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      row_acc_r <= '0;
    end else begin
      if (cmd.accept) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : ROW_W'(row_sat + 1'b1);
        end else begin
          col_r <= COL_W'(col_sat + 1'b1);
          row_r <= row_sat;
        end
      end
      if (cmd.comb && !cfg.layout_column) begin
        row_acc_r <= acc_new;
      end
    end
  end

  // restoring divider, one quotient bit per step
  logic [ACC_W-1:0]           acc_r;
  logic [rcpr_pkg::Q_W-1:0]   q_r;
  logic                       sat_r;
  logic [DIV_W-1:0]           acc_ext, trial, ceil_val;
  logic                       ge;

  assign acc_ext  = DIV_W'(acc_r);
  assign trial    = DIV_W'(cnt_r) << cmd.div_idx;
  assign ceil_val = DIV_W'(cnt_r) << rcpr_pkg::Q_W;
  assign ge       = (acc_ext >= trial);

  always_ff @(posedge clk) begin
    if (cmd.comb) begin
      acc_r <= acc_new;
    end else if (cmd.div_step && ge) begin
      acc_r <= ACC_W'(acc_ext - trial);
    end
    if (cmd.div_chk) begin
      sat_r <= (acc_ext >= ceil_val);
      q_r   <= '0;
    end else if (cmd.div_step) begin
      q_r[cmd.div_idx] <= ge;
    end
  end

  // final value with saturation
  logic [rcpr_pkg::PIX_W-1:0] fin_val;

  always_comb begin
    if (sts.mean) begin
      fin_val = sat_r ? rcpr_pkg::PIX_MAX : q_r;
    end else if (acc_r > ACC_W'(rcpr_pkg::PIX_MAX)) begin
      fin_val = rcpr_pkg::PIX_MAX;
    end else begin
      fin_val = acc_r[rcpr_pkg::PIX_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_reduced_value <= fin_val;
      out_line_index    <= line_r;
      out_last_of_frame <= lastf_r;
    end
  end

  assign sts.emit = emit_r;
  assign sts.mean = (cfg.reduce_mode != rcpr_pkg::MODE_MIN) &&
                    (cfg.reduce_mode != rcpr_pkg::MODE_MAX);

endmodule
`default_nettype wire

// ----- hw/rtl/row_column_projection_reducer.sv -----
// Reduces each row or each column of an 8-bit raster plane to its minimum,
// maximum or truncated mean. Pixels enter on the in_ channel in raster order;
// a row result leaves with the row's last pixel, a column result while the
// frame's last row passes that column. One pixel is handled at a time: a
// pixel that gives no result is accepted, then read-modify-writes its
// accumulator; a min or max result goes to the result stage, and a mean result
// first passes the 8-step restoring divider that forms one quotient bit per
// cycle. The result sits in an output register, so the next pixel is taken
// while it waits; only a second result blocks on a stalled output. Column
// accumulators live in a MAX_WIDTH-entry RAM with no clearing pass; row 0 of
// each frame loads them. Write configuration only while the block is idle.
`default_nettype none
module row_column_projection_reducer #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [rcpr_pkg::CFG_ADDR_W-1:0]  cfg_index,
  input  wire logic [rcpr_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire logic [rcpr_pkg::PIX_W-1:0]       in_pixel,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      logic [rcpr_pkg::PIX_W-1:0]       out_reduced_value,
  output      logic [rcpr_pkg::IDX_W-1:0]       out_line_index,
  output      logic                             out_last_of_frame
);

  rcpr_pkg::cfg_t      cfg_r, cfg_nxt;
  rcpr_pkg::ctrl_cmd_t cmd;
  rcpr_pkg::dp_sts_t   sts;

  // configuration register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (rcpr_pkg::cfg_reg_t'(cfg_index))
        rcpr_pkg::CFG_REDUCE_MODE:   cfg_nxt.reduce_mode   = cfg_wdata[rcpr_pkg::MODE_W-1:0];
        rcpr_pkg::CFG_LAYOUT_COLUMN: cfg_nxt.layout_column = cfg_wdata[0];
        rcpr_pkg::CFG_FRAME_WIDTH:   cfg_nxt.frame_width   = cfg_wdata;
        rcpr_pkg::CFG_FRAME_HEIGHT:  cfg_nxt.frame_height  = cfg_wdata;
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reduce_mode   <= rcpr_pkg::MODE_MIN;
      cfg_r.layout_column <= 1'b0;
      cfg_r.frame_width   <= rcpr_pkg::CFG_W'(1);
      cfg_r.frame_height  <= rcpr_pkg::CFG_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rcpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rcpr_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .cmd               (cmd),
    .sts               (sts),
    .in_pixel          (in_pixel),
    .out_reduced_value (out_reduced_value),
    .out_line_index    (out_line_index),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
`default_nettype wire
